/* sv/swt_pkg.sv */
// Shared types, character codes and sizing constants for the shell word tokenizer.
`default_nettype none
package swt_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] ChPipe   = 8'h7C;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreat  = 8'h3E;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChEnd    = 8'h00;

  typedef enum logic [1:0] {
    ModeOut  = 2'd0,
    ModeWord = 2'd1,
    ModeSq   = 2'd2,
    ModeDq   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KindByte    = 3'd0,
    KindWordEnd = 3'd1,
    KindOp      = 3'd2,
    KindDone    = 3'd3,
    KindErrSq   = 3'd4,
    KindErrDq   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNl);
  endfunction

  function automatic logic is_operator(logic [7:0] c);
    return (c == ChPipe) || (c == ChLess) || (c == ChGreat);
  endfunction

endpackage
`default_nettype wire

/* sv/shell_word_tokenizer_core.sv */
// Top level of the shell word tokenizer: front end, result queue and back end.
// A byte is taken every cycle while the queue has room; its first result passes through
// the queue and the back end output register. A byte with two results holds the back
// end until both are sent, so the output port sets the sustained rate of one result
// per cycle while out_stall_i is low.
// Reset is asynchronous and active low; it empties the queue and clears the quoting state.
`default_nettype none
module shell_word_tokenizer_core #(
  parameter int unsigned QueueDepth = swt_pkg::QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      result_kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  logic            accept, push, full, pop, nonempty;
  swt_pkg::entry_t push_entry, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  swt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  swt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .nonempty_o   (nonempty),
    .head_o       (head)
  );

  swt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nonempty_i    (nonempty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

/* sv/swt_front.sv */
// Front end: holds the quoting state, classifies each input byte and builds its results.
`default_nettype none
module swt_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          char_i,
  output logic                     push_o,
  output swt_pkg::entry_t          entry_o
);

  swt_pkg::mode_e mode_q, mode_d;
  logic           esc_q, esc_d;
  logic           has_result;

  always_comb begin
    mode_d = mode_q;
    esc_d  = 1'b0;
    if (esc_q && (char_i != swt_pkg::ChEnd)) begin
      if (mode_q == swt_pkg::ModeOut) begin
        mode_d = swt_pkg::ModeWord;
      end
    end else begin
      case (mode_q)
        swt_pkg::ModeOut: begin
          if (char_i == swt_pkg::ChEnd || swt_pkg::is_blank(char_i) ||
              swt_pkg::is_operator(char_i)) begin
            mode_d = swt_pkg::ModeOut;
          end else if (char_i == swt_pkg::ChSquote) begin
            mode_d = swt_pkg::ModeSq;
          end else if (char_i == swt_pkg::ChDquote) begin
            mode_d = swt_pkg::ModeDq;
          end else if (char_i == swt_pkg::ChBslash) begin
            esc_d = 1'b1;
          end else begin
            mode_d = swt_pkg::ModeWord;
          end
        end
        swt_pkg::ModeWord: begin
          if (char_i == swt_pkg::ChEnd || swt_pkg::is_blank(char_i) ||
              swt_pkg::is_operator(char_i)) begin
            mode_d = swt_pkg::ModeOut;
          end else if (char_i == swt_pkg::ChBslash) begin
            esc_d = 1'b1;
          end else if (char_i == swt_pkg::ChSquote) begin
            mode_d = swt_pkg::ModeSq;
          end else if (char_i == swt_pkg::ChDquote) begin
            mode_d = swt_pkg::ModeDq;
          end
        end
        swt_pkg::ModeSq: begin
          if (char_i == swt_pkg::ChEnd) begin
            mode_d = swt_pkg::ModeOut;
          end else if (char_i == swt_pkg::ChSquote) begin
            mode_d = swt_pkg::ModeWord;
          end
        end
        swt_pkg::ModeDq: begin
          if (char_i == swt_pkg::ChEnd) begin
            mode_d = swt_pkg::ModeOut;
          end else if (char_i == swt_pkg::ChDquote) begin
            mode_d = swt_pkg::ModeWord;
          end else if (char_i == swt_pkg::ChBslash) begin
            esc_d = 1'b1;
          end
        end
        default: begin
          mode_d = swt_pkg::ModeOut;
        end
      endcase
    end
  end

  always_comb begin
    has_result          = 1'b0;
    entry_o.two         = 1'b0;
    entry_o.first.kind  = swt_pkg::KindByte;
    entry_o.first.data  = char_i;
    entry_o.second.kind = swt_pkg::KindDone;
    entry_o.second.data = '0;
    if (esc_q && (char_i != swt_pkg::ChEnd)) begin
      has_result = 1'b1;
      if (mode_q == swt_pkg::ModeDq && char_i == swt_pkg::ChLowerN) begin
        entry_o.first.data = swt_pkg::ChNl;
      end else if (mode_q == swt_pkg::ModeDq && char_i == swt_pkg::ChLowerT) begin
        entry_o.first.data = swt_pkg::ChTab;
      end
    end else begin
      case (mode_q)
        swt_pkg::ModeOut: begin
          if (char_i == swt_pkg::ChEnd) begin
            has_result         = 1'b1;
            entry_o.first.kind = swt_pkg::KindDone;
            entry_o.first.data = '0;
          end else if (swt_pkg::is_operator(char_i)) begin
            has_result         = 1'b1;
            entry_o.first.kind = swt_pkg::KindOp;
          end else if (!swt_pkg::is_blank(char_i) && char_i != swt_pkg::ChSquote &&
                       char_i != swt_pkg::ChDquote && char_i != swt_pkg::ChBslash) begin
            has_result = 1'b1;
          end
        end
        swt_pkg::ModeWord: begin
          if (char_i == swt_pkg::ChEnd || swt_pkg::is_blank(char_i) ||
              swt_pkg::is_operator(char_i)) begin
            has_result          = 1'b1;
            entry_o.first.kind  = swt_pkg::KindWordEnd;
            entry_o.first.data  = '0;
            entry_o.two         = !swt_pkg::is_blank(char_i);
            entry_o.second.kind = (char_i == swt_pkg::ChEnd) ? swt_pkg::KindDone
                                                              : swt_pkg::KindOp;
            entry_o.second.data = char_i;
          end else if (char_i != swt_pkg::ChBslash && char_i != swt_pkg::ChSquote &&
                       char_i != swt_pkg::ChDquote) begin
            has_result = 1'b1;
          end
        end
        swt_pkg::ModeSq: begin
          if (char_i == swt_pkg::ChEnd) begin
            has_result         = 1'b1;
            entry_o.first.kind = swt_pkg::KindErrSq;
            entry_o.first.data = '0;
          end else if (char_i != swt_pkg::ChSquote) begin
            has_result = 1'b1;
          end
        end
        swt_pkg::ModeDq: begin
          if (char_i == swt_pkg::ChEnd) begin
            has_result         = 1'b1;
            entry_o.first.kind = swt_pkg::KindErrDq;
            entry_o.first.data = '0;
          end else if (char_i != swt_pkg::ChDquote && char_i != swt_pkg::ChBslash) begin
            has_result = 1'b1;
          end
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
    push_o = accept_i && has_result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= swt_pkg::ModeOut;
      esc_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
    end
  end

endmodule
`default_nettype wire

/* sv/swt_fifo.sv */
// Short queue of result groups between the front end and the back end.
`default_nettype none
module swt_fifo #(
  parameter int unsigned Depth = swt_pkg::QueueDepthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire swt_pkg::entry_t push_entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 nonempty_o,
  output swt_pkg::entry_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  swt_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/swt_back.sv */
// Back end: takes result groups from the queue and sends one result per beat.
`default_nettype none
module swt_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            nonempty_i,
  input  wire swt_pkg::entry_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [2:0]           result_kind_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_run_o
);

  swt_pkg::entry_t cur_q;
  logic            cur_valid_q, cur_valid_d;
  logic            idx_q, idx_d;
  logic            out_accept, finishing;
  swt_pkg::result_t sel;

  assign sel           = idx_q ? cur_q.second : cur_q.first;
  assign out_valid_o   = cur_valid_q;
  assign result_kind_o = sel.kind;
  assign out_byte_o    = sel.data;
  assign last_of_run_o = idx_q || !cur_q.two;

  assign out_accept = cur_valid_q && !out_stall_i;
  assign finishing  = out_accept && last_of_run_o;
  assign pop_o      = nonempty_i && (!cur_valid_q || finishing);

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = 1'b0;
    end else if (finishing) begin
      cur_valid_d = 1'b0;
    end else if (out_accept) begin
      idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

endmodule
`default_nettype wire

/* verif/token_stream_checker.sv */
// Checker for the shell word tokenizer: predicts the result beats and compares them.
`timescale 1ns / 100ps
module token_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] char_in_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] result_kind_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_of_run_i,
  output int         error_count_o,
  output int         tokens_due_o,
  output int         results_seen_o
);

  typedef struct packed {
    swt_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } token_t;

  token_t         tokens_due[$];
  swt_pkg::mode_e lex_mode;
  logic           esc_pending;
  int             errors;
  int             seen;

  function automatic void push_token(input swt_pkg::kind_e k, input logic [7:0] d);
    token_t t;
    t.kind = k;
    t.data = d;
    t.last = 1'b0;
    tokens_due.push_back(t);
  endfunction

  function automatic void predict_tokens(input logic [7:0] c);
    int     first;
    logic   blank;
    logic   oper;
    token_t t;
    first = tokens_due.size();
    blank = c inside {swt_pkg::ChSpace, swt_pkg::ChTab, swt_pkg::ChNl};
    oper  = c inside {swt_pkg::ChPipe, swt_pkg::ChLess, swt_pkg::ChGreat};
    if (esc_pending && c != swt_pkg::ChEnd) begin
      esc_pending = 1'b0;
      if (lex_mode == swt_pkg::ModeDq) begin
        if (c == swt_pkg::ChLowerN) push_token(swt_pkg::KindByte, swt_pkg::ChNl);
        else if (c == swt_pkg::ChLowerT) push_token(swt_pkg::KindByte, swt_pkg::ChTab);
        else push_token(swt_pkg::KindByte, c);
      end else begin
        push_token(swt_pkg::KindByte, c);
        if (lex_mode == swt_pkg::ModeOut) lex_mode = swt_pkg::ModeWord;
      end
    end else begin
      esc_pending = 1'b0;
      case (lex_mode)
        swt_pkg::ModeOut: begin
          if (c == swt_pkg::ChEnd) push_token(swt_pkg::KindDone, 8'h00);
          else if (blank) ;
          else if (oper) push_token(swt_pkg::KindOp, c);
          else if (c == swt_pkg::ChSquote) lex_mode = swt_pkg::ModeSq;
          else if (c == swt_pkg::ChDquote) lex_mode = swt_pkg::ModeDq;
          else if (c == swt_pkg::ChBslash) esc_pending = 1'b1;
          else begin
            push_token(swt_pkg::KindByte, c);
            lex_mode = swt_pkg::ModeWord;
          end
        end
        swt_pkg::ModeWord: begin
          if (c == swt_pkg::ChEnd) begin
            push_token(swt_pkg::KindWordEnd, 8'h00);
            push_token(swt_pkg::KindDone, 8'h00);
            lex_mode = swt_pkg::ModeOut;
          end else if (blank) begin
            push_token(swt_pkg::KindWordEnd, 8'h00);
            lex_mode = swt_pkg::ModeOut;
          end else if (oper) begin
            push_token(swt_pkg::KindWordEnd, 8'h00);
            push_token(swt_pkg::KindOp, c);
            lex_mode = swt_pkg::ModeOut;
          end else if (c == swt_pkg::ChBslash) esc_pending = 1'b1;
          else if (c == swt_pkg::ChSquote) lex_mode = swt_pkg::ModeSq;
          else if (c == swt_pkg::ChDquote) lex_mode = swt_pkg::ModeDq;
          else push_token(swt_pkg::KindByte, c);
        end
        swt_pkg::ModeSq: begin
          if (c == swt_pkg::ChEnd) begin
            push_token(swt_pkg::KindErrSq, 8'h00);
            lex_mode = swt_pkg::ModeOut;
          end else if (c == swt_pkg::ChSquote) lex_mode = swt_pkg::ModeWord;
          else push_token(swt_pkg::KindByte, c);
        end
        default: begin
          if (c == swt_pkg::ChEnd) begin
            push_token(swt_pkg::KindErrDq, 8'h00);
            lex_mode = swt_pkg::ModeOut;
          end else if (c == swt_pkg::ChDquote) lex_mode = swt_pkg::ModeWord;
          else if (c == swt_pkg::ChBslash) esc_pending = 1'b1;
          else push_token(swt_pkg::KindByte, c);
        end
      endcase
    end
    if (tokens_due.size() > first) begin
      t = tokens_due.pop_back();
      t.last = 1'b1;
      tokens_due.push_back(t);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    if (!rst_ni) begin
      tokens_due.delete();
      lex_mode    = swt_pkg::ModeOut;
      esc_pending = 1'b0;
      errors      = 0;
      seen        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (tokens_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat kind %0d byte %02h last %0b", $time,
                   result_kind_i, out_byte_i, last_of_run_i);
        end else begin
          want = tokens_due.pop_front();
          if (result_kind_i !== want.kind) begin
            errors++;
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                     result_kind_i);
          end
          if (out_byte_i !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data,
                     out_byte_i);
          end
          if (last_of_run_i !== want.last) begin
            errors++;
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.last,
                     last_of_run_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_tokens(char_in_i);
    end
    error_count_o  <= errors;
    tokens_due_o   <= tokens_due.size();
    results_seen_o <= seen;
  end

endmodule

/* verif/testbench.sv */
// Top of the tokenizer testbench: clock, reset, command line stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int CycleLimit = 400000;
  localparam int ByteTarget = 1900;
  localparam logic [7:0] OpChars [3] = '{swt_pkg::ChPipe, swt_pkg::ChLess,
                                         swt_pkg::ChGreat};
  localparam logic [7:0] BlankChars [3] = '{swt_pkg::ChSpace, swt_pkg::ChTab,
                                            swt_pkg::ChNl};

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_in_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] result_kind_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  int   error_count;
  int   tokens_due;
  int   results_seen;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   lines_sent = 0;
  bit   idle_on = 1'b1;
  logic [7:0] line_q[$];

  shell_word_tokenizer_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_in_i    (char_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  token_stream_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .char_in_i     (char_in_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_i (result_kind_o),
    .out_byte_i    (out_byte_o),
    .last_of_run_i (last_of_run_o),
    .error_count_o (error_count),
    .tokens_due_o  (tokens_due),
    .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(0, 99) < 18);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 18) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    char_in_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (b == swt_pkg::ChEnd) lines_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tokens_due != 0);
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h61, 8'h7a));
    do c = 8'($urandom_range(1, 255));
    while (c inside {swt_pkg::ChSpace, swt_pkg::ChTab, swt_pkg::ChNl, swt_pkg::ChPipe,
                     swt_pkg::ChLess, swt_pkg::ChGreat, swt_pkg::ChBslash,
                     swt_pkg::ChSquote, swt_pkg::ChDquote});
    return c;
  endfunction

  function automatic void add_word();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 5))
        0, 1: repeat ($urandom_range(1, 4)) line_q.push_back(plain_char());
        2: begin
          line_q.push_back(swt_pkg::ChBslash);
          line_q.push_back(8'($urandom_range(1, 255)));
        end
        3: begin
          line_q.push_back(swt_pkg::ChSquote);
          repeat ($urandom_range(0, 4)) begin
            line_q.push_back(any_but(swt_pkg::ChSquote, swt_pkg::ChSquote));
          end
          line_q.push_back(swt_pkg::ChSquote);
        end
        default: begin
          line_q.push_back(swt_pkg::ChDquote);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
              line_q.push_back(swt_pkg::ChBslash);
              case ($urandom_range(0, 2))
                0: line_q.push_back(swt_pkg::ChLowerN);
                1: line_q.push_back(swt_pkg::ChLowerT);
                default: line_q.push_back(8'($urandom_range(1, 255)));
              endcase
            end else begin
              line_q.push_back(any_but(swt_pkg::ChDquote, swt_pkg::ChBslash));
            end
          end
          line_q.push_back(swt_pkg::ChDquote);
        end
      endcase
    end
  endfunction

  function automatic void add_gap();
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1)) line_q.push_back(swt_pkg::ChSpace);
      line_q.push_back(OpChars[$urandom_range(0, 2)]);
      if ($urandom_range(0, 1)) line_q.push_back(swt_pkg::ChSpace);
    end else begin
      repeat ($urandom_range(1, 2)) line_q.push_back(BlankChars[$urandom_range(0, 2)]);
    end
  endfunction

  function automatic void build_line();
    int words;
    int shape;
    line_q.delete();
    words = $urandom_range(0, 5);
    shape = $urandom_range(0, 9);
    if ($urandom_range(0, 4) == 0) add_gap();
    for (int w = 0; w < words; w++) begin
      add_word();
      if (w < words - 1) add_gap();
    end
    if ($urandom_range(0, 4) == 0) add_gap();
    if (shape == 8) begin
      case ($urandom_range(0, 2))
        0: line_q.push_back(swt_pkg::ChSquote);
        1: line_q.push_back(swt_pkg::ChDquote);
        default: line_q.push_back(swt_pkg::ChBslash);
      endcase
      if ($urandom_range(0, 1)) line_q.push_back(plain_char());
      if ($urandom_range(0, 1)) line_q.push_back(swt_pkg::ChBslash);
    end else if (shape == 9) begin
      line_q.delete();
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end
    line_q.push_back(swt_pkg::ChEnd);
  endfunction

  initial begin
    logic [7:0] opening[$];
    bit paused_mid;
    paused_mid = 1'b0;
    opening = '{8'hFF, swt_pkg::ChPipe, swt_pkg::ChLess, swt_pkg::ChSquote,
                swt_pkg::ChSquote, swt_pkg::ChSpace, swt_pkg::ChDquote, swt_pkg::ChBslash,
                swt_pkg::ChLowerN, swt_pkg::ChBslash, swt_pkg::ChLowerT, swt_pkg::ChBslash,
                swt_pkg::ChDquote, swt_pkg::ChDquote, swt_pkg::ChGreat, swt_pkg::ChBslash,
                swt_pkg::ChSpace, swt_pkg::ChBslash, swt_pkg::ChEnd, swt_pkg::ChSquote,
                swt_pkg::ChBslash, swt_pkg::ChEnd, swt_pkg::ChDquote, swt_pkg::ChBslash,
                swt_pkg::ChEnd, swt_pkg::ChTab, swt_pkg::ChNl, swt_pkg::ChEnd};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening[i]) send_byte(opening[i]);
    wait_drained();
    while (bytes_sent < ByteTarget) begin
      idle_on <= !(bytes_sent >= 900 && bytes_sent < 1300);
      if (!paused_mid && bytes_sent >= 1000) begin
        paused_mid = 1'b1;
        wait_drained();
      end
      build_line();
      foreach (line_q[i]) send_byte(line_q[i]);
    end
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d command line bytes in %0d lines, with quoting, escapes and errors.",
             bytes_sent, lines_sent);
    $display("Checked %0d result beats under random input gaps and output stalls.",
             results_seen);
    if (error_count == 0 && tokens_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
